FILE: hdl/pol_pkg.sv
// shared codes and types for the positional ordered list
package pol_pkg;

  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_POS   = 3'd2;
  localparam logic [2:0] FN_DEL_FRONT = 3'd3;
  localparam logic [2:0] FN_DEL_BACK  = 3'd4;
  localparam logic [2:0] FN_DEL_POS   = 3'd5;
  localparam logic [2:0] FN_LIST      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   idx;
    logic [POS_W-1:0]   cnt;
  } cell_ctrl_t;

endpackage

FILE: hdl/pol_cell.sv
// one storage cell of the list row
module pol_cell
  import pol_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [VAL_W-1:0]  left_value,
  input  logic [VAL_W-1:0]  right_value,
  input  logic [VAL_W-1:0]  head_value,
  input  logic [VAL_W-1:0]  new_value,
  output logic [VAL_W-1:0]  value
);

  localparam logic [POS_W-1:0] J  = POS_W'(IDX);
  localparam logic [POS_W-1:0] J1 = POS_W'(IDX + 1);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_HOLD: begin
        value <= value;
      end
      OP_INS: begin
        if (J == ctrl.idx) begin
          value <= new_value;
        end else if (J > ctrl.idx) begin
          value <= left_value;
        end
      end
      OP_DEL: begin
        if (J >= ctrl.idx) begin
          value <= right_value;
        end
      end
      OP_ROT: begin
        // the head value wraps around into the last occupied cell
        if (J1 == ctrl.cnt) begin
          value <= head_value;
        end else begin
          value <= right_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

FILE: hdl/positional_ordered_list.sv
// top level of the positional ordered list
// Keeps up to DEPTH signed values in a row of cells that all shift in the same cycle.
// Insert and delete leave busy low, and the single result appears with done in the next cycle,
// so a new item can be started every cycle. A list item raises busy and gives one result per
// cycle, front first, by rotating the occupied cells once around the row; the last result
// carries last, and busy falls with it. A list of an empty row, and every rejected item, gives
// one result in the next cycle; an unused function code gives none. Results cannot be held
// off: each is valid only in the cycle in which done is high. No clearing after reset.
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                func,
  input  logic signed [VAL_W-1:0]   item_value,
  input  logic [POS_W-1:0]          position,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [VAL_W-1:0]   out_value,
  output logic                      last
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [POS_W-1:0] DEPTH_C = POS_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t             state;
  logic [POS_W-1:0]   count;
  logic [IW-1:0]      list_i;
  cell_ctrl_t         ctrl;
  logic [VAL_W-1:0]   cell_value [DEPTH];
  logic               accept;
  logic               full;
  logic               empty;
  logic               ins_ok;
  logic               del_ok;
  logic [POS_W-1:0]   ins_idx;
  logic [POS_W-1:0]   del_idx;
  logic               list_end;

  assign busy     = (state == S_LIST);
  assign accept   = start && (state == S_IDLE);
  assign full     = (count >= DEPTH_C);
  assign empty    = (count == '0);
  assign list_end = (POS_W'(list_i) + POS_W'(1) == count);

  always_comb begin
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    ins_idx = '0;
    del_idx = '0;
    unique case (func)
      FN_INS_FRONT: begin
        ins_ok  = !full;
      end
      FN_INS_BACK: begin
        ins_ok  = !full;
        ins_idx = count;
      end
      FN_INS_POS: begin
        ins_ok  = !full && (position != '0) && (position <= count + POS_W'(1));
        ins_idx = position - POS_W'(1);
      end
      FN_DEL_FRONT: begin
        del_ok  = !empty;
      end
      FN_DEL_BACK: begin
        del_ok  = !empty;
        del_idx = count - POS_W'(1);
      end
      FN_DEL_POS: begin
        del_ok  = !empty && (position != '0) && (position <= count);
        del_idx = position - POS_W'(1);
      end
      default: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.op  = OP_HOLD;
    ctrl.idx = '0;
    ctrl.cnt = count;
    if (state == S_LIST) begin
      ctrl.op = OP_ROT;
    end else if (accept && ins_ok) begin
      ctrl.op  = OP_INS;
      ctrl.idx = ins_idx;
    end else if (accept && del_ok) begin
      ctrl.op  = OP_DEL;
      ctrl.idx = del_idx;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = item_value;
    end else begin : g_inner_l
      assign left_v = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_v = cell_value[g];
    end else begin : g_inner_r
      assign right_v = cell_value[g+1];
    end
    pol_cell #(
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .right_value (right_v),
      .head_value  (cell_value[0]),
      .new_value   (item_value),
      .value       (cell_value[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      list_i <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status    <= ST_OK;
            out_value <= '0;
            last      <= 1'b1;
            list_i    <= '0;
            unique case (func)
              FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else if (!ins_ok) begin
                  status <= ST_BADPOS;
                end else begin
                  count <= count + POS_W'(1);
                end
              end
              FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
                done <= 1'b1;
                if (empty) begin
                  status <= ST_EMPTY;
                end else if (!del_ok) begin
                  status <= ST_BADPOS;
                end else begin
                  out_value <= cell_value[del_idx[IW-1:0]];
                  count     <= count - POS_W'(1);
                end
              end
              FN_LIST: begin
                if (empty) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  state <= S_LIST;
                end
              end
              default: begin
                done <= 1'b0;
              end
            endcase
          end
        end
        S_LIST: begin
          done      <= 1'b1;
          status    <= ST_OK;
          out_value <= cell_value[0];
          last      <= list_end;
          list_i    <= list_i + IW'(1);
          if (list_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/testbench.sv
// testbench for the positional ordered list: directed and random items against a queue model
`timescale 1ns / 100ps

module testbench;
  import pol_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [2:0] FN_UNUSED = 3'd7;

  typedef struct {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              func = FN_INS_FRONT;
  logic signed [VAL_W-1:0] item_value = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    done;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;

  logic signed [VAL_W-1:0] stored_values[$];
  list_result_t            pending_results[$];
  int                      errors = 0;
  int                      burst_left = 0;
  int                      idle_cycles = 0;

  positional_ordered_list #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .item_value(item_value),
    .position(position),
    .done(done),
    .status(status),
    .out_value(out_value),
    .last(last)
  );

  always #2 clk = ~clk;

  function automatic void queue_result(logic [1:0] st, logic signed [VAL_W-1:0] v, logic l);
    list_result_t r;
    r.status = st;
    r.value = v;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // list model, updated in the order items are accepted
  task automatic predict_list_op(input logic [2:0] f, input logic signed [VAL_W-1:0] v,
                                 input logic [POS_W-1:0] p);
    int n;
    int i;
    logic signed [VAL_W-1:0] removed;
    n = stored_values.size();
    case (f)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
        if (n >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else if (f == FN_INS_FRONT) begin
          stored_values.push_front(v);
          queue_result(ST_OK, '0, 1'b1);
        end else if (f == FN_INS_BACK) begin
          stored_values.push_back(v);
          queue_result(ST_OK, '0, 1'b1);
        end else if (p < 1 || p > n + 1) begin
          queue_result(ST_BADPOS, '0, 1'b1);
        end else begin
          stored_values.insert(p - 1, v);
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else if (f == FN_DEL_FRONT) begin
          removed = stored_values.pop_front();
          queue_result(ST_OK, removed, 1'b1);
        end else if (f == FN_DEL_BACK) begin
          removed = stored_values.pop_back();
          queue_result(ST_OK, removed, 1'b1);
        end else if (p < 1 || p > n) begin
          queue_result(ST_BADPOS, '0, 1'b1);
        end else begin
          removed = stored_values[p - 1];
          stored_values.delete(p - 1);
          queue_result(ST_OK, removed, 1'b1);
        end
      end
      FN_LIST: begin
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) queue_result(ST_OK, stored_values[i], i == n - 1);
        end
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_item(input logic [2:0] f, input logic signed [VAL_W-1:0] v,
                           input logic [POS_W-1:0] p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 4) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    func <= f;
    item_value <= v;
    position <= p;
    do @(posedge clk); while (busy);
    predict_list_op(f, v, p);
  endtask

  task automatic send_random_insert();
    logic [2:0] f;
    logic [POS_W-1:0] p;
    case ($urandom_range(0, 2))
      0: f = FN_INS_FRONT;
      1: f = FN_INS_BACK;
      default: f = FN_INS_POS;
    endcase
    p = (f == FN_INS_POS) ? POS_W'($urandom_range(1, stored_values.size() + 1)) :
        POS_W'($urandom_range(0, 127));
    send_item(f, $urandom, p);
  endtask

  task automatic send_random_delete();
    logic [2:0] f;
    logic [POS_W-1:0] p;
    case ($urandom_range(0, 2))
      0: f = FN_DEL_FRONT;
      1: f = FN_DEL_BACK;
      default: f = FN_DEL_POS;
    endcase
    p = (f == FN_DEL_POS && stored_values.size() > 0) ?
        POS_W'($urandom_range(1, stored_values.size())) : POS_W'($urandom_range(0, 127));
    send_item(f, $urandom, p);
  endtask

  task automatic test_empty_list();
    send_item(FN_DEL_FRONT, 32'sd5, 7'd0);
    send_item(FN_DEL_BACK, -32'sd5, 7'd1);
    send_item(FN_DEL_POS, 32'sd0, 7'd1);
    send_item(FN_LIST, 32'sd0, 7'd0);
    send_item(FN_INS_POS, 32'sd9, 7'd0);
    send_item(FN_INS_POS, 32'sd9, 7'd2);
    send_item(FN_UNUSED, 32'sd1, 7'd1);
  endtask

  task automatic test_basic_ops();
    send_item(FN_INS_FRONT, 32'sh7fffffff, 7'd0);
    send_item(FN_INS_BACK, 32'sh80000000, 7'd127);
    send_item(FN_INS_POS, 32'sd0, 7'd2);
    send_item(FN_INS_POS, -32'sd1, 7'd4);
    send_item(FN_INS_POS, 32'sd1, 7'd1);
    send_item(FN_LIST, 32'sd0, 7'd0);
    send_item(FN_DEL_POS, 32'sd0, 7'd0);
    send_item(FN_DEL_POS, 32'sd0, 7'd6);
    send_item(FN_INS_POS, 32'sd3, 7'd127);
    send_item(FN_DEL_POS, 32'sd0, 7'd3);
    send_item(FN_DEL_FRONT, 32'sd0, 7'd0);
    send_item(FN_DEL_BACK, 32'sd0, 7'd0);
    send_item(FN_DEL_POS, 32'sd0, 7'd2);
    send_item(FN_LIST, 32'sd0, 7'd0);
    send_item(FN_DEL_POS, 32'sd0, 7'd1);
    send_item(FN_UNUSED, -32'sd1, 7'd127);
    send_item(FN_LIST, 32'sd0, 7'd0);
  endtask

  task automatic test_fill_and_drain();
    while (stored_values.size() < DEPTH) send_random_insert();
    send_item(FN_INS_FRONT, $urandom, 7'd0);
    send_item(FN_INS_BACK, $urandom, 7'd0);
    send_item(FN_INS_POS, $urandom, 7'd0);
    send_item(FN_INS_POS, $urandom, 7'd127);
    send_item(FN_INS_POS, $urandom, 7'd1);
    send_item(FN_LIST, $urandom, 7'd0);
    send_item(FN_DEL_POS, $urandom, 7'd65);
    while (stored_values.size() > 0) begin
      if ($urandom_range(0, 9) == 0)
        send_item(FN_DEL_POS, $urandom,
                  POS_W'($urandom_range(stored_values.size() + 1, 127)));
      else
        send_random_delete();
    end
    send_item(FN_LIST, $urandom, 7'd0);
  endtask

  task automatic test_random_mix(input int n_items);
    int k;
    int r;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_random_insert();
      else if (r < 85) send_random_delete();
      else if (r < 90) send_item(FN_LIST, $urandom, POS_W'($urandom_range(0, 127)));
      else if (r < 97) send_item(3'($urandom_range(0, 6)), $urandom,
                                 POS_W'($urandom_range(0, 127)));
      else send_item(FN_UNUSED, $urandom, POS_W'($urandom_range(0, 127)));
    end
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: status %0d value %0d last %0b", status, out_value, last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || out_value !== want.value || last !== want.last) begin
          if (errors < 10)
            $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                     want.status, want.value, want.last, status, out_value, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_fill_and_drain();
    test_random_mix(145);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pol_pkg.sv
hdl/pol_cell.sv
hdl/positional_ordered_list.sv
dv/testbench.sv
